@@ hdl/dcpw_pkg.sv @@
package dcpw_pkg;

  // Display bus command codes
  localparam logic [7:0] CMD_COLUMN_SET     = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET       = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE   = 8'h2C;
  localparam logic [7:0] CMD_ACCESS_CONTROL = 8'h36;

  // Access-control bits that pick the axis mapping
  localparam int unsigned MADCTL_MV_BIT = 5;
  localparam int unsigned MADCTL_MX_BIT = 6;

  // Parameter byte counter saturates here
  localparam logic [2:0] PARAM_COUNT_MAX = 3'd5;
  localparam logic [2:0] PARAM_COUNT_ONE = 3'd1;
  localparam logic [2:0] PARAM_COUNT_LAST = 3'd3;   // count before the fourth byte

  // Configuration register map
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  localparam logic [8:0] FRAME_WIDTH_RESET  = 9'd320;
  localparam logic [7:0] FRAME_HEIGHT_RESET = 8'd240;

  typedef struct packed {
    logic [8:0]  frame_x;
    logic [7:0]  frame_y;
    logic [15:0] pixel_color;
  } pixel_t;

endpackage

@@ hdl/dcpw_out_skid.sv @@
module dcpw_out_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  dcpw_pkg::pixel_t push_pix,
  output logic            full,
  output logic            out_valid,
  output dcpw_pkg::pixel_t out_pix,
  input  logic            out_stall
);
  import dcpw_pkg::*;

  logic   out_valid_r;
  logic   skid_valid_r;
  pixel_t out_pix_r;
  pixel_t skid_pix_r;
  logic   out_take;

  // push_valid is never high while the skid slot is occupied (full stalls input)
  assign out_take = out_valid_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_take) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (push_valid) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_pix_r <= skid_pix_r;
      end
    end else if (push_valid) begin
      if (!out_valid_r || out_take) begin
        out_pix_r <= push_pix;
      end else begin
        skid_pix_r <= push_pix;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

endmodule

@@ hdl/display_command_pixel_writer_core.sv @@
// Display command pixel writer: takes one display-bus beat per clock (data/command bit plus
// byte), decodes column-set, page-set, access-control and memory-write commands, pairs
// pixel bytes (high first) into RGB565 and emits one result beat per pixel that maps
// inside the configured landscape frame. Command and parameter state update at the clock
// edge that accepts the beat, so an input beat is taken every cycle that in_stall is low;
// the pixel result is registered into the output stage by the beat carrying its low
// byte. A two-entry output stage (result register plus skid slot) lets input continue
// while a result waits; in_stall rises only when both entries are held by a stalled
// output. Pixels outside the frame still advance the cursor but produce no result.
// cfg_ready is always high; frame_width/frame_height should be written only while the
// block is idle. Writes to unknown register indexes are ignored. PANEL_COLUMNS/PANEL_ROWS
// set the panel size that limits cursor wrap and the portrait-to-landscape mapping.
module display_command_pixel_writer_core #(
  parameter int unsigned PANEL_COLUMNS = 240,
  parameter int unsigned PANEL_ROWS    = 320
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input beats
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_is_data,
  input  logic [7:0]                       in_data_byte,
  // result beats
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [8:0]                       out_frame_x,
  output logic [7:0]                       out_frame_y,
  output logic [15:0]                      out_pixel_color,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dcpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dcpw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dcpw_pkg::*;

  localparam logic [15:0] COL_LIMIT = 16'(PANEL_COLUMNS);
  localparam logic [15:0] ROW_LIMIT = 16'(PANEL_ROWS);
  localparam logic [16:0] COL_LAST  = 17'(PANEL_COLUMNS - 1);
  localparam logic [16:0] ROW_LAST  = 17'(PANEL_ROWS - 1);

  // config
  logic [8:0]  frame_width_r;
  logic [7:0]  frame_height_r;

  // command state
  logic [7:0]  current_command_r;
  logic [7:0]  param_bytes_r [4];
  logic [2:0]  param_count_r;
  logic [15:0] win_x_start_r, win_x_end_r, win_y_start_r, win_y_end_r;
  logic [15:0] cursor_x_r, cursor_y_r;
  logic [7:0]  access_control_r;
  logic        in_pixel_mode_r;
  logic        low_byte_next_r;
  logic [7:0]  high_color_byte_r;

  logic        in_accept;
  logic        cmd_beat, param_beat, pixel_hi_beat, pixel_lo_beat;
  logic [2:0]  param_count_nxt;
  logic        load_col, load_page, load_madctl;

  // pixel datapath
  logic        swap_axes;
  logic [16:0] diff_x, diff_y;     // ROW_LAST - cursor_y, COL_LAST - cursor_x
  logic [15:0] fx, fy;
  logic        fx_neg, fy_neg;
  logic        in_frame;
  logic        push_valid;
  pixel_t      push_pix, out_pix;

  // cursor advance
  logic [15:0] cursor_x_inc, cursor_y_inc;
  logic [15:0] cursor_x_nxt, cursor_y_nxt;

  assign in_accept     = in_valid & ~in_stall;
  assign cmd_beat      = in_accept & ~in_is_data;
  assign param_beat    = in_accept & in_is_data & ~in_pixel_mode_r;
  assign pixel_hi_beat = in_accept & in_is_data & in_pixel_mode_r & ~low_byte_next_r;
  assign pixel_lo_beat = in_accept & in_is_data & in_pixel_mode_r & low_byte_next_r;

  assign param_count_nxt = (param_count_r < PARAM_COUNT_MAX) ? param_count_r + 3'd1
                                                              : param_count_r;
  assign load_col    = param_beat && current_command_r == CMD_COLUMN_SET
                       && param_count_r == PARAM_COUNT_LAST;
  assign load_page   = param_beat && current_command_r == CMD_PAGE_SET
                       && param_count_r == PARAM_COUNT_LAST;
  assign load_madctl = param_beat && current_command_r == CMD_ACCESS_CONTROL
                       && param_count_nxt == PARAM_COUNT_ONE;

  // Portrait panel -> landscape frame; negative results (borrow) never land in the frame
  assign swap_axes = access_control_r[MADCTL_MV_BIT] ^ access_control_r[MADCTL_MX_BIT];
  assign diff_x    = ROW_LAST - {1'b0, cursor_y_r};
  assign diff_y    = COL_LAST - {1'b0, cursor_x_r};

  always_comb begin
    if (!swap_axes) begin
      fx     = diff_x[15:0];
      fx_neg = diff_x[16];
      fy     = cursor_x_r;
      fy_neg = 1'b0;
    end else begin
      fx     = cursor_y_r;
      fx_neg = 1'b0;
      fy     = diff_y[15:0];
      fy_neg = diff_y[16];
    end
  end

  assign in_frame = !fx_neg && !fy_neg && (fx < {7'd0, frame_width_r})
                    && (fy < {8'd0, frame_height_r});

  assign push_valid           = pixel_lo_beat & in_frame;
  assign push_pix.frame_x     = fx[8:0];
  assign push_pix.frame_y     = fy[7:0];
  assign push_pix.pixel_color = {high_color_byte_r, in_data_byte};

  // Cursor steps along x, wraps to the window start and moves to the next row
  assign cursor_x_inc = cursor_x_r + 16'd1;
  assign cursor_y_inc = cursor_y_r + 16'd1;

  always_comb begin
    cursor_x_nxt = cursor_x_inc;
    cursor_y_nxt = cursor_y_r;
    if (cursor_x_inc > win_x_end_r || cursor_x_inc >= COL_LIMIT) begin
      cursor_x_nxt = win_x_start_r;
      if (cursor_y_inc > win_y_end_r || cursor_y_inc >= ROW_LIMIT) begin
        cursor_y_nxt = win_y_start_r;
      end else begin
        cursor_y_nxt = cursor_y_inc;
      end
    end
  end

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_data[8:0];
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_data[7:0];
      end
    end
  end

  // command / parameter / pixel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_command_r <= '0;
      for (int i = 0; i < 4; i++) begin
        param_bytes_r[i] <= '0;
      end
      param_count_r     <= '0;
      win_x_start_r     <= '0;
      win_x_end_r       <= COL_LAST[15:0];
      win_y_start_r     <= '0;
      win_y_end_r       <= ROW_LAST[15:0];
      cursor_x_r        <= '0;
      cursor_y_r        <= '0;
      access_control_r  <= '0;
      in_pixel_mode_r   <= 1'b0;
      low_byte_next_r   <= 1'b0;
      high_color_byte_r <= '0;
    end else begin
      if (cmd_beat) begin
        current_command_r <= in_data_byte;
        param_count_r     <= '0;
        in_pixel_mode_r   <= (in_data_byte == CMD_MEMORY_WRITE);
        if (in_data_byte == CMD_MEMORY_WRITE) begin
          cursor_x_r      <= win_x_start_r;
          cursor_y_r      <= win_y_start_r;
          low_byte_next_r <= 1'b0;
        end
      end
      if (param_beat) begin
        if (!param_count_r[2]) begin
          param_bytes_r[param_count_r[1:0]] <= in_data_byte;
        end
        param_count_r <= param_count_nxt;
      end
      if (load_col) begin
        win_x_start_r <= {param_bytes_r[0], param_bytes_r[1]};
        win_x_end_r   <= {param_bytes_r[2], in_data_byte};
      end
      if (load_page) begin
        win_y_start_r <= {param_bytes_r[0], param_bytes_r[1]};
        win_y_end_r   <= {param_bytes_r[2], in_data_byte};
      end
      if (load_madctl) begin
        access_control_r <= in_data_byte;
      end
      if (pixel_hi_beat) begin
        high_color_byte_r <= in_data_byte;
        low_byte_next_r   <= 1'b1;
      end
      if (pixel_lo_beat) begin
        low_byte_next_r <= 1'b0;
        cursor_x_r      <= cursor_x_nxt;
        cursor_y_r      <= cursor_y_nxt;
      end
    end
  end

  // result register + skid slot
  dcpw_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_pix  (push_pix),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_pix   (out_pix),
    .out_stall (out_stall)
  );

  assign out_frame_x     = out_pix.frame_x;
  assign out_frame_y     = out_pix.frame_y;
  assign out_pixel_color = out_pix.pixel_color;

`ifndef SYNTHESIS
  // input only stalls when a result is held on the output
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall high with no pending result");

  a_pixel_mode_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_pixel_mode_r |-> (current_command_r == CMD_MEMORY_WRITE))
    else $error("pixel mode outside memory-write");

  a_param_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    param_count_r <= PARAM_COUNT_MAX)
    else $error("parameter count beyond saturation");

  a_cmd_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_is_data) |=> (param_count_r == 3'd0))
    else $error("command beat did not clear parameter count");

  // a result only follows a low-byte pixel beat
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> $past(pixel_lo_beat))
    else $error("result without a pixel beat");
`endif

endmodule

@@ tb/sv/pixel_write_checker.sv @@
module pixel_write_checker #(
  parameter int unsigned PANEL_COLUMNS = 240,
  parameter int unsigned PANEL_ROWS    = 320
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_is_data,
  input  logic [7:0]                       in_data_byte,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [8:0]                       out_frame_x,
  input  logic [7:0]                       out_frame_y,
  input  logic [15:0]                      out_pixel_color,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [dcpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dcpw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             end_check,
  output int                               fail_count,
  output int                               pending
);
  import dcpw_pkg::*;

  localparam int MAX_PRINTS = 100;
  localparam logic [2:0] PARAM_SLOTS = 3'd4;

  pixel_t      expected_pixels[$];
  int          mismatches = 0;
  logic        end_done;

  // shadow of the decoder state
  logic [7:0]  cur_cmd;
  logic [7:0]  parm [4];
  logic [2:0]  parm_cnt;
  logic [15:0] win_xs, win_xe, win_ys, win_ye;
  logic [15:0] cur_x, cur_y;
  logic [7:0]  madctl;
  logic        pix_mode;
  logic        low_next;
  logic [7:0]  hi_byte;
  logic [8:0]  frame_w;
  logic [7:0]  frame_h;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic take_param(input logic [7:0] b);
    if (parm_cnt < PARAM_SLOTS) parm[parm_cnt[1:0]] = b;
    if (parm_cnt < PARAM_COUNT_MAX) parm_cnt = parm_cnt + 3'd1;
    if (cur_cmd == CMD_COLUMN_SET && parm_cnt == PARAM_SLOTS) begin
      win_xs = {parm[0], parm[1]};
      win_xe = {parm[2], parm[3]};
    end else if (cur_cmd == CMD_PAGE_SET && parm_cnt == PARAM_SLOTS) begin
      win_ys = {parm[0], parm[1]};
      win_ye = {parm[2], parm[3]};
    end else if (cur_cmd == CMD_ACCESS_CONTROL && parm_cnt == PARAM_COUNT_ONE) begin
      madctl = b;
    end
  endtask

  task automatic step_cursor();
    cur_x = cur_x + 16'd1;
    if (cur_x > win_xe || cur_x >= PANEL_COLUMNS) begin
      cur_x = win_xs;
      cur_y = cur_y + 16'd1;
      if (cur_y > win_ye || cur_y >= PANEL_ROWS) cur_y = win_ys;
    end
  endtask

  task automatic decode_bus_beat(input logic is_data, input logic [7:0] b);
    logic [31:0] fx;
    logic [31:0] fy;
    pixel_t      px;
    if (!is_data) begin
      cur_cmd  = b;
      parm_cnt = '0;
      pix_mode = (b == CMD_MEMORY_WRITE);
      if (pix_mode) begin
        cur_x    = win_xs;
        cur_y    = win_ys;
        low_next = 1'b0;
      end
    end else if (!pix_mode) begin
      take_param(b);
    end else if (!low_next) begin
      hi_byte  = b;
      low_next = 1'b1;
    end else begin
      low_next = 1'b0;
      // 32-bit subtraction: a negative coordinate wraps huge and drops out
      if (!(madctl[MADCTL_MV_BIT] ^ madctl[MADCTL_MX_BIT])) begin
        fx = PANEL_ROWS - 1 - cur_y;
        fy = cur_x;
      end else begin
        fx = cur_y;
        fy = PANEL_COLUMNS - 1 - cur_x;
      end
      step_cursor();
      if (fx < frame_w && fy < frame_h) begin
        px.frame_x     = fx[8:0];
        px.frame_y     = fy[7:0];
        px.pixel_color = {hi_byte, b};
        expected_pixels.push_back(px);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    pixel_t want;
    if (!rst_n) begin
      expected_pixels.delete();
      end_done = 1'b0;
      cur_cmd  = '0;
      foreach (parm[i]) parm[i] = '0;
      parm_cnt = '0;
      win_xs   = '0;
      win_xe   = 16'd239;
      win_ys   = '0;
      win_ye   = 16'd319;
      cur_x    = '0;
      cur_y    = '0;
      madctl   = '0;
      pix_mode = 1'b0;
      low_next = 1'b0;
      hi_byte  = '0;
      frame_w  = FRAME_WIDTH_RESET;
      frame_h  = FRAME_HEIGHT_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel beat with none expected, x", 32'(out_frame_x), '0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_frame_x !== want.frame_x)
            report_mismatch("frame_x", 32'(out_frame_x), 32'(want.frame_x));
          if (out_frame_y !== want.frame_y)
            report_mismatch("frame_y", 32'(out_frame_y), 32'(want.frame_y));
          if (out_pixel_color !== want.pixel_color)
            report_mismatch("pixel_color", 32'(out_pixel_color), 32'(want.pixel_color));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_w = cfg_data[8:0];
        else if (cfg_index == REG_FRAME_HEIGHT) frame_h = cfg_data[7:0];
      end
      if (in_valid && !in_stall) decode_bus_beat(in_is_data, in_data_byte);
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (expected_pixels.size() != 0)
          report_mismatch("pixel beats never delivered", expected_pixels.size(), '0);
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

@@ tb/sv/display_command_pixel_writer_core_tb.sv @@
module display_command_pixel_writer_core_tb;
  import dcpw_pkg::*;

  localparam int CYCLE_LIMIT    = 500000; // far above the slowest legal run
  localparam int ITEM_TARGET    = 1750;   // beats sent in the random part, noise beats not counted
  localparam int SEQ_PER_PHASE  = 10;     // command sequences between config changes
  localparam int PRESSURE_PHASE = 2;
  localparam int LONG_HOLD      = 400;    // receiver hold-off, in cycles
  localparam int SETTLE         = 8;      // quiet cycles before a config write
  localparam int DRAIN_WAIT     = 5000;
  localparam int TAIL           = 20;
  localparam int MAX_GAP        = 12;

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_is_data   = 1'b0;
  logic [7:0]             in_data_byte = '0;
  logic                   out_stall    = 1'b0;
  logic                   cfg_valid    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   end_check    = 1'b0;

  logic                   in_stall;
  logic                   out_valid;
  logic [8:0]             out_frame_x;
  logic [7:0]             out_frame_y;
  logic [15:0]            out_pixel_color;
  logic                   cfg_ready;

  int fail_count;
  int pending;

  // quiet: no random gaps on either side for the current phase
  logic quiet      = 1'b0;
  int   hold_req   = 0;
  int   hold_ack   = 0;
  int   stall_left = 0;
  int   cycles     = 0;
  int   beats_sent = 0;
  int   ignored    = 0;

  display_command_pixel_writer_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_is_data      (in_is_data),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_x     (out_frame_x),
    .out_frame_y     (out_frame_y),
    .out_pixel_color (out_pixel_color),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // predicts every pixel beat from the bus beats and compares what comes out
  pixel_write_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_is_data      (in_is_data),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_x     (out_frame_x),
    .out_frame_y     (out_frame_y),
    .out_pixel_color (out_pixel_color),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .end_check       (end_check),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: after each accepted beat draw a random stall, none while quiet.
  // A hold request from the stimulus replaces that with one long hold-off,
  // counted here, so the output stage fills and in_stall must rise.
  // Exactly one nonblocking write to out_stall per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (hold_ack != hold_req) begin
        hold_ack   = hold_req;
        stall_left = LONG_HOLD;
      end else if (out_valid && !out_stall) begin
        stall_left = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One bus beat: optional gap with valid low, then hold the payload until
  // taken. With no gap, valid simply stays high for the next beat.
  task automatic send_beat(input logic is_data, input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_is_data   <= is_data;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Column-set or page-set with start and end, high byte first
  task automatic send_window(input logic [7:0] cmd, input logic [15:0] ws,
                             input logic [15:0] we);
    send_beat(1'b0, cmd);
    send_beat(1'b1, ws[15:8]);
    send_beat(1'b1, ws[7:0]);
    send_beat(1'b1, we[15:8]);
    send_beat(1'b1, we[7:0]);
  endtask

  // Memory-write followed by n random pixel bytes (odd n leaves a half pixel)
  task automatic send_pixels(input int n);
    send_beat(1'b0, CMD_MEMORY_WRITE);
    repeat (n) send_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid, wait out every pending pixel, then let the pipe settle.
  // The first edge lets the checker count the last accepted beat.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The trailing edge keeps cfg_valid from being lowered and raised in one step
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          sel;
    int          n;
    int          phase;
    int          w;
    int          lim;
    logic [7:0]  cmd;
    logic [15:0] ws;
    logic [15:0] we;
    logic [8:0]  wval;
    logic [7:0]  hval;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset frame size ----
    // parameter bytes before any command land on command zero
    send_beat(1'b1, 8'hFF);
    send_beat(1'b1, 8'h00);
    // portrait origin maps to the far right column of the frame
    send_beat(1'b0, CMD_MEMORY_WRITE);
    send_beat(1'b1, 8'hFF);
    send_beat(1'b1, 8'hFF);
    send_beat(1'b1, 8'h00);
    send_beat(1'b1, 8'h00);
    // a lone high byte, then a command: pixel mode ends, pairing is kept
    send_beat(1'b1, 8'hA5);
    send_beat(1'b0, CMD_ACCESS_CONTROL);
    // bit 5 alone selects the swapped mapping
    send_beat(1'b1, 8'h20);
    send_beat(1'b0, CMD_MEMORY_WRITE);
    send_beat(1'b1, 8'h5A);
    send_beat(1'b1, 8'hC3);
    // window at the top of the 16-bit range plus a fifth, ignored byte:
    // first pixel maps negative and is dropped, the cursor wraps to zero
    send_window(CMD_COLUMN_SET, 16'hFFFF, 16'hFFFF);
    send_beat(1'b1, 8'h12);
    send_beat(1'b0, CMD_MEMORY_WRITE);
    send_beat(1'b1, 8'h80);
    send_beat(1'b1, 8'h01);
    send_beat(1'b1, 8'h7E);
    send_beat(1'b1, 8'hFE);

    // ---- random part, phases split by config writes at idle ----
    beats_sent = 0;
    phase      = 0;
    while (beats_sent - ignored < ITEM_TARGET) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       wval = 9'd0;
        1:       wval = 9'd1;
        2:       wval = 9'd320;
        3:       wval = 9'h1FF;
        default: wval = 9'($urandom_range(100, 320));
      endcase
      case ($urandom_range(0, 7))
        0:       hval = 8'd0;
        1:       hval = 8'd1;
        2:       hval = 8'd240;
        3:       hval = 8'hFF;
        default: hval = 8'($urandom_range(100, 240));
      endcase
      if (phase == PRESSURE_PHASE) begin
        wval = 9'd320;
        hval = 8'd240;
      end
      write_reg(REG_FRAME_WIDTH, wval);
      // bit 8 is outside the height register and must not matter
      write_reg(REG_FRAME_HEIGHT, {1'($urandom_range(0, 1)), hval});
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
      quiet <= (phase == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);

      if (phase == PRESSURE_PHASE) begin
        // full panel window, then a long pixel burst against a held receiver
        send_window(CMD_COLUMN_SET, 16'd0, 16'd239);
        send_window(CMD_PAGE_SET, 16'd0, 16'd319);
        send_beat(1'b0, CMD_ACCESS_CONTROL);
        send_beat(1'b1, 8'h00);
        hold_req <= hold_req + 1;
        send_pixels(160);
        // sender waits for every pixel before going on
        wait_idle();
      end

      repeat (SEQ_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          send_pixels($urandom_range(1, 40));
        end else if (sel < 70) begin
          cmd = $urandom_range(0, 1) ? CMD_COLUMN_SET : CMD_PAGE_SET;
          lim = (cmd == CMD_COLUMN_SET) ? 239 : 319;
          if ($urandom_range(0, 7) == 0) begin
            ws = 16'($urandom);
            we = 16'($urandom);
          end else begin
            // small windows so the cursor wraps often
            ws = 16'($urandom_range(0, lim));
            we = ws + 16'($urandom_range(0, 12));
          end
          send_window(cmd, ws, we);
          if ($urandom_range(0, 5) == 0) send_beat(1'b1, 8'($urandom_range(0, 255)));
        end else if (sel < 82) begin
          send_beat(1'b0, CMD_ACCESS_CONTROL);
          repeat ($urandom_range(1, 2)) send_beat(1'b1, 8'($urandom_range(0, 255)));
        end else begin
          // noise: random commands and bytes, truncated sequences included
          n = $urandom_range(1, 4);
          repeat (n) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          ignored += n;
        end
      end
      phase++;
    end

    // ---- drain and verdict ----
    in_valid <= 1'b0;
    @(posedge clk);
    for (w = 0; w < DRAIN_WAIT && pending != 0; w++) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
